@@ hw/rtl/keypad_matrix_port_with_ghosting_defines.svh @@
// assertion macros for the keypad port
`ifndef KEYPAD_MATRIX_PORT_WITH_GHOSTING_DEFINES_SVH
`define KEYPAD_MATRIX_PORT_WITH_GHOSTING_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define KMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    localparam int BUS_W = 8;
    localparam int GRP_W = 3;
    localparam int KBIT_W = 3;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PRESS   = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BUS_W-1:0]  bus_data;
        logic [GRP_W-1:0]  key_group;
        logic [KBIT_W-1:0] key_bit;
        logic              is_on_key;
    } t_key_item;

    typedef struct packed {
        logic      valid;
        t_key_item item;
    } t_key_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/keypad_matrix_port_with_ghosting.sv @@
// a port read is held in the input register, then its result in the result register
// throughput: one word per cycle, reads stall only while the result waits
// reset: i_rst_n synchronous active low, clears the key matrix, the group
// select mask, the on flag and both valid flags
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_matrix_port_with_ghosting_defines.svh"

module keypad_matrix_port_with_ghosting
    import kmp_pkg::*;
#(
    parameter int NUM_GROUPS     = 7,
    parameter int KEYS_PER_GROUP = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // bus_data[7:0], key_group[10:8], key_bit[13:11]
    input  wire logic [2:0]  i_s_tuser,  // op[1:0], is_on_key[2]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // read_data[7:0]
    output logic [0:0]       o_m_tuser   // on_key[0]
);

    t_key_item                                 r_in;
    t_key_item                                 n_in;
    logic                                      r_in_valid;
    logic                                      n_in_valid;
    logic                                      r_out_valid;
    logic                                      n_out_valid;
    logic [BUS_W-1:0]                          r_out_data;
    logic [BUS_W-1:0]                          n_out_data;
    logic                                      r_out_on;
    logic                                      n_out_on;
    logic                                      w_advance;
    logic                                      w_is_read;
    t_key_cmd                                  w_cmd;
    logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0] w_matrix;
    logic [BUS_W-1:0]                          w_select;
    logic                                      w_on;
    logic [BUS_W-1:0]                          w_read_data;

    assign w_is_read  = (r_in.op == OP_READ);
    assign w_advance  = r_in_valid && (!w_is_read || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    assign w_cmd.valid = w_advance;
    assign w_cmd.item  = r_in;

    kmp_keys #(
        .NUM_GROUPS     (NUM_GROUPS),
        .KEYS_PER_GROUP (KEYS_PER_GROUP)
    ) u_keys (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_matrix (w_matrix),
        .o_select (w_select),
        .o_on     (w_on)
    );

    kmp_ghost #(
        .NUM_GROUPS     (NUM_GROUPS),
        .KEYS_PER_GROUP (KEYS_PER_GROUP)
    ) u_ghost (
        .i_matrix    (w_matrix),
        .i_select    (w_select),
        .o_read_data (w_read_data)
    );

    always_comb begin
        n_in       = r_in;
        n_in_valid = r_in_valid;
        if (i_s_tvalid && o_s_tready) begin
            n_in.op        = t_op'(i_s_tuser[1:0]);
            n_in.is_on_key = i_s_tuser[2];
            n_in.bus_data  = i_s_tdata[7:0];
            n_in.key_group = i_s_tdata[10:8];
            n_in.key_bit   = i_s_tdata[13:11];
            n_in_valid     = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_on    = r_out_on;
        if (w_advance && w_is_read) begin
            n_out_valid = 1'b1;
            n_out_data  = w_read_data;
            n_out_on    = w_on;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_out_data <= n_out_data;
        r_out_on   <= n_out_on;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_on;

    `KMP_ASSERT_NEXT(a_read_gives_word, w_advance && w_is_read, o_m_tvalid, "read lost")
    `KMP_ASSERT_NOW(a_read_stalls, r_in_valid && w_is_read && r_out_valid && !i_m_tready, !o_s_tready, "read overran result")
    `KMP_ASSERT_NEXT(a_write_sets_select, w_advance && r_in.op == OP_WRITE, w_select == ~$past(r_in.bus_data), "select not stored")
    `KMP_ASSERT_NEXT(a_on_press, w_advance && r_in.op == OP_PRESS && r_in.is_on_key, w_on, "on flag not set")

endmodule

`default_nettype wire

@@ hw/rtl/kmp_keys.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmp_keys
    import kmp_pkg::*;
#(
    parameter int NUM_GROUPS     = 7,
    parameter int KEYS_PER_GROUP = 8
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire t_key_cmd                                      i_cmd,
    output logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0]          o_matrix,
    output logic [BUS_W-1:0]                                   o_select,
    output logic                                               o_on
);

    logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0] r_matrix;
    logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0] n_matrix;
    logic [BUS_W-1:0]                          r_select;
    logic [BUS_W-1:0]                          n_select;
    logic                                      r_on;
    logic                                      n_on;
    logic                                      w_press;

    assign w_press = (i_cmd.item.op == OP_PRESS);

    always_comb begin
        n_matrix = r_matrix;
        n_select = r_select;
        n_on     = r_on;
        if (i_cmd.valid) begin
            case (i_cmd.item.op)
                OP_WRITE: begin
                    n_select = ~i_cmd.item.bus_data;
                end
                OP_PRESS, OP_RELEASE: begin
                    if (i_cmd.item.is_on_key) begin
                        n_on = w_press;
                    end else begin
                        // out-of-range group or bit matches no entry
                        for (int g = 0; g < NUM_GROUPS; g++) begin
                            for (int b = 0; b < KEYS_PER_GROUP; b++) begin
                                if (i_cmd.item.key_group == GRP_W'(g) &&
                                    i_cmd.item.key_bit == KBIT_W'(b)) begin
                                    n_matrix[g][b] = w_press;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_on = r_on;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= '0;
            r_select <= '0;
            r_on     <= 1'b0;
        end else begin
            r_matrix <= n_matrix;
            r_select <= n_select;
            r_on     <= n_on;
        end
    end

    assign o_matrix = r_matrix;
    assign o_select = r_select;
    assign o_on     = r_on;

endmodule

`default_nettype wire

@@ hw/rtl/kmp_ghost.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmp_ghost
    import kmp_pkg::*;
#(
    parameter int NUM_GROUPS     = 7,
    parameter int KEYS_PER_GROUP = 8
) (
    input  wire logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0] i_matrix,
    input  wire logic [BUS_W-1:0]                          i_select,
    output logic [BUS_W-1:0]                               o_read_data
);

    logic [NUM_GROUPS-1:0][KEYS_PER_GROUP-1:0] w_merged;
    logic [KEYS_PER_GROUP-1:0]                 w_acc;
    logic [BUS_W-1:0]                          w_acc_ext;

    // single pass merge: row g picks up every row sharing a pressed bit
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_merged[g] = '0;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                if (|(i_matrix[g] & i_matrix[i])) begin
                    w_merged[g] = w_merged[g] | i_matrix[g] | i_matrix[i];
                end
            end
        end
    end

    always_comb begin
        w_acc = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (i_select[g]) begin
                w_acc = w_acc | w_merged[g];
            end
        end
        w_acc_ext = '0;
        w_acc_ext[KEYS_PER_GROUP-1:0] = w_acc;
    end

    assign o_read_data = ~w_acc_ext;

endmodule

`default_nettype wire

@@ sim/keypad_matrix_port_with_ghosting_test.sv @@
`timescale 1ns / 1ps

module keypad_matrix_port_with_ghosting_test;
    import kmp_pkg::*;

    localparam int NUM_GROUPS     = 7;
    localparam int KEYS_PER_GROUP = 8;
    localparam int RANDOM_WORDS   = 1550;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       on_key;
    } t_key_result;

    class keypad_scoreboard;
        logic [7:0]  key_rows [NUM_GROUPS];
        logic [7:0]  group_sel;
        logic        on_flag;
        t_key_result reads_due [$];
        int          errors;

        function new();
            foreach (key_rows[g]) key_rows[g] = '0;
            group_sel = '0;
            on_flag = 1'b0;
            errors = 0;
        endfunction

        // one pass of ghosting: merge every row that shares a pressed key with row g
        function logic [7:0] ghosted_row(int g);
            logic [7:0] merged;
            merged = '0;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                if ((key_rows[g] & key_rows[i]) != 8'h00) begin
                    merged = merged | key_rows[g] | key_rows[i];
                end
            end
            return merged;
        endfunction

        function void note_word(t_key_item w);
            logic [7:0]  acc;
            t_key_result r;
            case (w.op)
                OP_READ: begin
                    acc = '0;
                    for (int g = 0; g < NUM_GROUPS; g++) begin
                        if (group_sel[g]) begin
                            acc = acc | ghosted_row(g);
                        end
                    end
                    r.read_data = ~acc;
                    r.on_key = on_flag;
                    reads_due.push_back(r);
                end
                OP_WRITE: begin
                    group_sel = ~w.bus_data;
                end
                default: begin
                    if (w.is_on_key) begin
                        on_flag = (w.op == OP_PRESS);
                    end else if (w.key_group < NUM_GROUPS && w.key_bit < KEYS_PER_GROUP) begin
                        key_rows[w.key_group][w.key_bit] = (w.op == OP_PRESS);
                    end
                end
            endcase
        endfunction

        task report(string what);
            if (errors < 50) begin
                $display("%0t ns: %s", $time, what);
            end
            errors++;
        endtask

        task check_word(logic [7:0] data, logic on);
            t_key_result want;
            if (reads_due.size() == 0) begin
                report($sformatf("read word with none due: data=%h on=%b", data, on));
            end else begin
                want = reads_due.pop_front();
                if (data !== want.read_data) begin
                    report($sformatf("read_data %h, predicted %h", data, want.read_data));
                end
                if (on !== want.on_key) begin
                    report($sformatf("on_key %b, predicted %b", on, want.on_key));
                end
            end
        endtask

        function int pending();
            return reads_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic [15:0] s_tdata;   // bus_data[7:0], key_group[10:8], key_bit[13:11]
    logic [2:0]  s_tuser;   // op[1:0], is_on_key[2]
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;   // read_data[7:0]
    wire  [0:0]  m_tuser;   // on_key[0]

    keypad_scoreboard sb = new();
    int  cycles = 0;
    int  rx_wait = 0;
    logic rx_blocked = 1'b0;
    logic tx_calm = 1'b0;

    keypad_matrix_port_with_ghosting #(
        .NUM_GROUPS(NUM_GROUPS),
        .KEYS_PER_GROUP(KEYS_PER_GROUP)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task send_word(t_key_item w);
        int gap;
        gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, w.key_bit, w.key_group, w.bus_data};
        s_tuser <= {w.is_on_key, w.op};
        do @(posedge i_clk); while (!s_tready);
        sb.note_word(w);
    endtask

    task send_fields(t_op op, logic [7:0] bus, logic [2:0] grp, logic [2:0] kbit, logic on);
        t_key_item w;
        w.op = op;
        w.bus_data = bus;
        w.key_group = grp;
        w.key_bit = kbit;
        w.is_on_key = on;
        send_word(w);
    endtask

    function automatic t_key_item random_word(bit press_heavy);
        t_key_item w;
        int r;
        r = $urandom_range(0, 99);
        w.bus_data = 8'($urandom_range(0, 255));
        w.key_group = 3'($urandom_range(0, 7));
        w.key_bit = 3'($urandom_range(0, 7));
        w.is_on_key = ($urandom_range(0, 9) == 0);
        if (r < 30) begin
            w.op = OP_READ;
        end else if (r < 42) begin
            w.op = OP_WRITE;
            if ($urandom_range(0, 1) == 1) begin
                w.bus_data = ~(8'h01 << $urandom_range(0, 7));
            end
        end else if ($urandom_range(0, 99) < (press_heavy ? 75 : 25)) begin
            w.op = OP_PRESS;
        end else begin
            w.op = OP_RELEASE;
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata, m_tuser[0]);
            end
            if (rx_blocked) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= 1'b0;
            end else if (((cycles / 2000) % 4) == 3 || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                rx_wait <= pick_gap();
                m_tready <= 1'b0;
            end
        end
    end

    // long receiver hold-offs so the port backs up and stalls its input
    initial begin
        repeat (2) begin
            repeat (800) @(posedge i_clk);
            rx_blocked <= 1'b1;
            repeat (400) @(posedge i_clk);
            rx_blocked <= 1'b0;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, extremes, ignored events, ghosting, unused select bits
        send_fields(OP_READ,    8'hAA, 3'd5, 3'd6, 1'b1);
        send_fields(OP_WRITE,   8'h00, 3'd7, 3'd7, 1'b1);
        send_fields(OP_PRESS,   8'hFF, 3'd0, 3'd0, 1'b0);
        send_fields(OP_PRESS,   8'h00, 3'd6, 3'd7, 1'b0);
        send_fields(OP_PRESS,   8'h55, 3'd7, 3'd3, 1'b0);
        send_fields(OP_PRESS,   8'h00, 3'd7, 3'd5, 1'b1);
        send_fields(OP_READ,    8'h00, 3'd0, 3'd0, 1'b0);
        send_fields(OP_PRESS,   8'h00, 3'd1, 3'd2, 1'b0);
        send_fields(OP_PRESS,   8'h00, 3'd2, 3'd2, 1'b0);
        send_fields(OP_PRESS,   8'h00, 3'd2, 3'd5, 1'b0);
        send_fields(OP_WRITE,   8'hFD, 3'd0, 3'd0, 1'b0);
        send_fields(OP_READ,    8'hFF, 3'd7, 3'd7, 1'b0);
        send_fields(OP_WRITE,   8'h7F, 3'd0, 3'd0, 1'b0);
        send_fields(OP_READ,    8'h00, 3'd0, 3'd0, 1'b0);
        send_fields(OP_RELEASE, 8'h00, 3'd2, 3'd2, 1'b0);
        send_fields(OP_WRITE,   8'hFD, 3'd0, 3'd0, 1'b0);
        send_fields(OP_READ,    8'h00, 3'd0, 3'd0, 1'b0);
        send_fields(OP_RELEASE, 8'h00, 3'd0, 3'd0, 1'b1);
        send_fields(OP_RELEASE, 8'hFF, 3'd7, 3'd7, 1'b0);
        send_fields(OP_WRITE,   8'h80, 3'd0, 3'd0, 1'b0);
        send_fields(OP_READ,    8'h00, 3'd0, 3'd0, 1'b0);
        send_fields(OP_RELEASE, 8'h00, 3'd0, 3'd0, 1'b0);
        send_fields(OP_RELEASE, 8'h00, 3'd6, 3'd7, 1'b0);
        send_fields(OP_WRITE,   8'hFF, 3'd0, 3'd0, 1'b0);
        send_fields(OP_READ,    8'h00, 3'd0, 3'd0, 1'b0);

        // random: alternate press-heavy and release-heavy stretches
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            tx_calm = (n >= 700 && n < 900);
            send_word(random_word(((n / 150) % 2) == 0));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d predicted read words never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
